// ===== rtl/assert_macros.svh =====
// assert_macros.svh: concurrent assertion macros for the sorted key table
// expects i_clk and i_rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define SKT_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("skt assertion failed: invariant");

// consequent holds in the cycle after the antecedent
`define SKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("skt assertion failed: next-cycle check");

`endif

// ===== rtl/skt_pkg.sv =====
// skt_pkg: types, codes and default sizes for the sorted key table
// no dependencies
package skt_pkg;

    // default sizes
    localparam int CAPACITY_DEF    = 16;
    localparam int KEY_BITS_DEF    = 16;
    localparam int HANDLE_BITS_DEF = 16;

    // fixed item field widths
    localparam int KEY_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 5;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        t_func               func;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic                found;
        logic [HANDLE_W-1:0] handle_out;
        logic [COUNT_W-1:0]  count;
    } t_out_item;

    // broadcast shift commands to every cell
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } t_cell_ctl;

    // per-cell compare results, also handed to the right neighbor
    typedef struct packed {
        logic le;
        logic lt;
        logic match;
        logic first;
    } t_cell_flags;

endpackage

// ===== rtl/skt_cell.sv =====
// skt_cell: one table position holding a key and handle
// compares against the broadcast key and shifts with its neighbors; uses skt_pkg
module skt_cell
    import skt_pkg::*;
#(
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic                   i_occ,
    input  logic [KEY_BITS-1:0]    i_key_in,
    input  logic [HANDLE_BITS-1:0] i_handle_in,
    input  logic [KEY_BITS-1:0]    i_left_key,
    input  logic [HANDLE_BITS-1:0] i_left_handle,
    input  t_cell_flags            i_left_flags,
    input  logic [KEY_BITS-1:0]    i_right_key,
    input  logic [HANDLE_BITS-1:0] i_right_handle,
    output logic [KEY_BITS-1:0]    o_key,
    output logic [HANDLE_BITS-1:0] o_handle,
    output t_cell_flags            o_flags,
    output logic [HANDLE_BITS-1:0] o_hsel
);

    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [KEY_BITS-1:0]    n_key;
    logic [HANDLE_BITS-1:0] n_handle;

    // local compares against the broadcast key
    always_comb begin
        o_flags.le    = i_occ && (r_key <= i_key_in);
        o_flags.lt    = i_occ && (r_key <  i_key_in);
        o_flags.match = i_occ && (r_key == i_key_in);
        o_flags.first = o_flags.match && !i_left_flags.match;
    end

    assign o_hsel   = o_flags.first ? r_handle : '0;
    assign o_key    = r_key;
    assign o_handle = r_handle;

    // insert opens a gap after the last key not above the new one;
    // remove closes the gap at the first match
    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        if (i_ctl.ins_en && !o_flags.le) begin
            if (i_left_flags.le) begin
                n_key    = i_key_in;
                n_handle = i_handle_in;
            end else begin
                n_key    = i_left_key;
                n_handle = i_left_handle;
            end
        end else if (i_ctl.rem_en && !o_flags.lt) begin
            n_key    = i_right_key;
            n_handle = i_right_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

endmodule

// ===== rtl/sorted_key_table.sv =====
// sorted_key_table: an accepted item's result is valid the next cycle
// throughput one item per cycle while the result is not held by i_out_stall; the result comes from the
// key compare in every cell and the reduction of their match flags that decides found, status and count
// the output register takes a new item while the previous result is being taken
// reset (synchronous, active low) empties the table and drops the pending result;
// entry contents stay unwritten, no clearing pass
`include "assert_macros.svh"

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_out_item              r_out;
    t_out_item              n_out;

    logic                   w_in_acc;
    logic                   w_out_acc;
    logic                   w_full;
    logic                   w_found;
    logic [KEY_BITS-1:0]    w_key_in;
    logic [HANDLE_BITS-1:0] w_handle_in;
    logic [HANDLE_BITS-1:0] w_hsel_or;
    t_cell_ctl              w_ctl;

    logic [CAPACITY-1:0]    w_occ;
    logic [CAPACITY-1:0]    w_match;
    logic [CAPACITY-1:0]    w_first;
    logic [KEY_BITS-1:0]    w_key    [CAPACITY];
    logic [HANDLE_BITS-1:0] w_handle [CAPACITY];
    logic [HANDLE_BITS-1:0] w_hsel   [CAPACITY];
    t_cell_flags            w_flags  [CAPACITY];

    // handshake
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_key_in    = KEY_BITS'(i_in_item.key);
    assign w_handle_in = HANDLE_BITS'(i_in_item.handle);
    assign w_full      = (r_count == CW'(CAPACITY));

    // row of cells
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [KEY_BITS-1:0]    l_left_key;
            logic [HANDLE_BITS-1:0] l_left_handle;
            t_cell_flags            l_left_flags;
            logic [KEY_BITS-1:0]    l_right_key;
            logic [HANDLE_BITS-1:0] l_right_handle;

            assign w_occ[g]   = (r_count > CW'(g));
            assign w_match[g] = w_flags[g].match;
            assign w_first[g] = w_flags[g].first;

            if (g == 0) begin : g_head
                assign l_left_key    = '0;
                assign l_left_handle = '0;
                assign l_left_flags  = '{le: 1'b1, lt: 1'b1, match: 1'b0, first: 1'b0};
            end else begin : g_mid
                assign l_left_key    = w_key[g-1];
                assign l_left_handle = w_handle[g-1];
                assign l_left_flags  = w_flags[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign l_right_key    = w_key[g];
                assign l_right_handle = w_handle[g];
            end else begin : g_body
                assign l_right_key    = w_key[g+1];
                assign l_right_handle = w_handle[g+1];
            end

            skt_cell #(
                .KEY_BITS    (KEY_BITS),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctl          (w_ctl),
                .i_occ          (w_occ[g]),
                .i_key_in       (w_key_in),
                .i_handle_in    (w_handle_in),
                .i_left_key     (l_left_key),
                .i_left_handle  (l_left_handle),
                .i_left_flags   (l_left_flags),
                .i_right_key    (l_right_key),
                .i_right_handle (l_right_handle),
                .o_key          (w_key[g]),
                .o_handle       (w_handle[g]),
                .o_flags        (w_flags[g]),
                .o_hsel         (w_hsel[g])
            );
        end
    endgenerate

    // at most one cell holds the first match, so an or picks its handle
    always_comb begin
        w_hsel_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hsel_or = w_hsel_or | w_hsel[i];
        end
    end

    assign w_found = |w_match;

    // operation decode, count update and result
    always_comb begin
        w_ctl       = '{ins_en: 1'b0, rem_en: 1'b0};
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = w_out_acc ? 1'b0 : r_out_valid;
        if (w_in_acc) begin
            n_out_valid      = 1'b1;
            n_out.status     = ST_OK;
            n_out.found      = 1'b0;
            n_out.handle_out = '0;
            case (i_in_item.func)
                FUNC_INSERT: begin
                    if (w_full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        w_ctl.ins_en = 1'b1;
                        n_count      = r_count + 1'b1;
                    end
                end
                FUNC_LOOKUP: begin
                    if (w_found) begin
                        n_out.found      = 1'b1;
                        n_out.handle_out = HANDLE_W'(w_hsel_or);
                    end else begin
                        n_out.status = ST_MISSING;
                    end
                end
                FUNC_REMOVE: begin
                    if (w_found) begin
                        n_out.found  = 1'b1;
                        w_ctl.rem_en = 1'b1;
                        n_count      = r_count - 1'b1;
                    end else begin
                        n_out.status = ST_MISSING;
                    end
                end
                FUNC_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
            n_out.count = COUNT_W'(n_count);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // checks
    `SKT_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(CAPACITY))
    `SKT_ASSERT_ALWAYS(a_first_unique, $onehot0(w_first))
    `SKT_ASSERT_NEXT(a_insert_grows, w_in_acc && i_in_item.func == FUNC_INSERT && !w_full, r_count == $past(r_count) + 1'b1)
    `SKT_ASSERT_NEXT(a_clear_empties, w_in_acc && i_in_item.func == FUNC_CLEAR, r_count == '0 && o_out_valid)

endmodule

// ===== tb/sv/tb_sorted_key_table.sv =====
// tb_sorted_key_table: self-checking testbench for the sorted key table
// depends on skt_pkg and sorted_key_table; keeps its own sorted table model
// and compares every result item field by field against it
module tb_sorted_key_table;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 4;
    localparam int POOL_N      = 8;
    localparam int SEG_ITEMS   = 30;
    localparam int RAND_SEGS   = 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // table model, kept sorted ascending by key
    logic [KEY_W-1:0]    tbl_keys[$];
    logic [HANDLE_W-1:0] tbl_handles[$];

    t_out_item pending_results[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    bit        no_idle = 1'b0;
    logic [KEY_W-1:0] key_pool[POOL_N];

    sorted_key_table i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    // wait cycles drawn per item, none during calm stretches
    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 15));
    endfunction

    // apply one operation to the table model and return its result item
    function automatic t_out_item apply_table_op(input t_in_item it);
        t_out_item r;
        int        pos;
        r = '0;
        r.status = ST_OK;
        pos = 0;
        case (it.func)
            FUNC_INSERT: begin
                if (tbl_keys.size() >= CAPACITY_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    // new entry goes after all equal keys
                    while (pos < tbl_keys.size() && tbl_keys[pos] <= it.key) pos++;
                    tbl_keys.insert(pos, it.key);
                    tbl_handles.insert(pos, it.handle);
                end
            end
            FUNC_LOOKUP, FUNC_REMOVE: begin
                while (pos < tbl_keys.size() && tbl_keys[pos] != it.key) pos++;
                if (pos == tbl_keys.size()) begin
                    r.status = ST_MISSING;
                end else begin
                    r.found = 1'b1;
                    if (it.func == FUNC_LOOKUP) begin
                        r.handle_out = tbl_handles[pos];
                    end else begin
                        tbl_keys.delete(pos);
                        tbl_handles.delete(pos);
                    end
                end
            end
            default: begin
                tbl_keys.delete();
                tbl_handles.delete();
            end
        endcase
        r.count = COUNT_W'(tbl_keys.size());
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) note_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    // send one item, predict its result once accepted
    task automatic send_item(input t_func f, input logic [KEY_W-1:0] k,
                             input logic [HANDLE_W-1:0] h);
        t_in_item it;
        int       gap;
        it = '{func: f, key: k, handle: h};
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(apply_table_op(it));
    endtask

    // result checker and receiver stall
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected result item %h", out_item));
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, out_item.status);
                    check_field("found", want.found, out_item.found);
                    check_field("handle_out", want.handle_out, out_item.handle_out);
                    check_field("count", want.count, out_item.count);
                end
                stall_left = draw_wait();
                out_stall <= (stall_left != 0);
            end else if (stall_left != 0) begin
                stall_left--;
                out_stall <= (stall_left != 0);
            end
        end
    end

    // watchdog on cycles without any accepted item or taken result
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // lookup, remove and clear on an empty table
    task automatic test_empty_table();
        send_item(FUNC_LOOKUP, 16'h0000, 16'hFFFF);
        send_item(FUNC_REMOVE, 16'hFFFF, 16'h0000);
        send_item(FUNC_CLEAR, 16'h1234, 16'h5678);
    endtask

    // duplicate keys, key and handle extremes, first-match lookup and remove
    task automatic test_duplicates();
        send_item(FUNC_INSERT, 16'h8000, 16'h0001);
        send_item(FUNC_INSERT, 16'h8000, 16'h0002);
        send_item(FUNC_INSERT, 16'h0000, 16'hFFFF);
        send_item(FUNC_INSERT, 16'hFFFF, 16'h0000);
        send_item(FUNC_LOOKUP, 16'h8000, 16'h0000);
        send_item(FUNC_REMOVE, 16'h8000, 16'h0000);
        send_item(FUNC_LOOKUP, 16'h8000, 16'h0000);
    endtask

    // fill to capacity, rejected insert, lookup, then clear a full table
    task automatic test_full_table();
        while (tbl_keys.size() < CAPACITY_DEF) begin
            send_item(FUNC_INSERT, KEY_W'($urandom), HANDLE_W'($urandom));
        end
        send_item(FUNC_INSERT, 16'h4000, 16'hAAAA);
        send_item(FUNC_LOOKUP, 16'hFFFF, 16'h0000);
        send_item(FUNC_CLEAR, 16'h0000, 16'h0000);
    endtask

    // key source: mostly keys in the table or a small pool, some fully random
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && tbl_keys.size() != 0) begin
            return tbl_keys[$urandom_range(0, tbl_keys.size() - 1)];
        end
        if (sel < 8) return key_pool[$urandom_range(0, POOL_N - 1)];
        return KEY_W'($urandom);
    endfunction

    // random operations in segments that lean toward filling or draining
    task automatic test_random_ops();
        int          ins_pct;
        int unsigned r;
        t_func       f;
        for (int seg = 0; seg < RAND_SEGS; seg++) begin
            ins_pct = ($urandom_range(0, 1) != 0) ? 70 : 25;
            no_idle = ($urandom_range(0, 3) == 0);
            foreach (key_pool[j]) begin
                case ($urandom_range(0, 7))
                    0:       key_pool[j] = '0;
                    1:       key_pool[j] = '1;
                    default: key_pool[j] = KEY_W'($urandom);
                endcase
            end
            for (int n = 0; n < SEG_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    f = FUNC_CLEAR;
                end else if (r < ins_pct) begin
                    f = FUNC_INSERT;
                end else if (r < ins_pct + (100 - ins_pct) / 2) begin
                    f = FUNC_LOOKUP;
                end else begin
                    f = FUNC_REMOVE;
                end
                send_item(f, pick_key(), HANDLE_W'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // main sequence
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_duplicates();
        test_full_table();
        test_random_ops();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_results.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
